// File: rtl/core/fan_pulse_safety_envelope_macros.svh
// ----------------------------------------------------------------------------
// fan_pulse_safety_envelope_macros
// Assertion macros used by the fan pulse safety envelope back end.
// ----------------------------------------------------------------------------
`ifndef FAN_PULSE_SAFETY_ENVELOPE_MACROS_SVH
`define FAN_PULSE_SAFETY_ENVELOPE_MACROS_SVH

`ifndef SYNTHESIS

`define FPSE_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("fpse: implication check failed");

`define FPSE_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("fpse: next-cycle check failed");

`else

`define FPSE_ASSERT_IMP(label, clk, rst, ante, cons)

`define FPSE_ASSERT_NXT(label, clk, rst, ante, cons)

`endif

`endif

// File: rtl/core/fpse_pkg.sv
// ----------------------------------------------------------------------------
// fpse_pkg
// Types, codes and constants of the fan pulse safety envelope.
// ----------------------------------------------------------------------------
`default_nettype none

package fpse_pkg;

  localparam int RPM_LIMIT   = 30000;
  localparam int COUNT_BITS  = 32;
  localparam int MIN_RPM     = 100;
  localparam int DUTY_MIN    = 20;
  localparam int DUTY_MAX    = 100;
  localparam int STALL_MARGIN = 10;
  localparam int PULSE_MIN   = 20;
  localparam int PULSE_MAX   = 2000;
  localparam int PULSE_RESET = 240;
  localparam int AMP_RESET   = 100;
  localparam int HZ_DIV      = 60 * 3;

  localparam int RPM_W      = $clog2(RPM_LIMIT + 1);
  localparam int SCALED_W   = $clog2(RPM_LIMIT * 100 + 1);
  localparam int DIV_CNT_W  = $clog2(SCALED_W + 1);
  localparam int DUTY_W     = 7;
  localparam int PULSE_W    = 11;
  localparam int HZ_W       = $clog2(RPM_LIMIT / HZ_DIV + 1);
  localparam int HZ_SHIFT   = 24;
  localparam int HZ_MUL     = ((1 << HZ_SHIFT) + HZ_DIV - 1) / HZ_DIV;
  localparam int HZ_MUL_W   = $clog2(HZ_MUL + 1);
  localparam int HZ_PROD_W  = RPM_W + HZ_MUL_W;

  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [2:0] {
    OP_ENABLE    = 3'd0,
    OP_DISABLE   = 3'd1,
    OP_CALIBRATE = 3'd2,
    OP_RPM       = 3'd3,
    OP_RUN       = 3'd4,
    OP_PULSE     = 3'd5
  } op_code_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_REFUSED = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    CMD_ENABLE,
    CMD_DISABLE,
    CMD_ENVELOPE,
    CMD_RUN,
    CMD_REFUSED,
    CMD_PULSE,
    CMD_INVALID
  } cmd_kind_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_SLOPE_GO,
    BK_SLOPE_WAIT,
    BK_FLOOR_GO,
    BK_FLOOR_WAIT,
    BK_EMIT
  } back_state_t;

  typedef struct packed {
    logic [2:0]         op;
    logic signed [31:0] value;
  } cmd_word_t;

  typedef struct packed {
    status_t     status;
    logic        calibrated;
    logic        enabled;
    logic [10:0] pulse_rate_hz;
    logic [6:0]  amplitude_level;
    logic [6:0]  min_duty_level;
    logic [7:0]  pulse_ceiling_hz;
    logic [6:0]  amplitude_ceiling;
    logic [21:0] rpm_slope;
    logic [31:0] run_total;
  } rsp_word_t;

  typedef struct packed {
    cmd_kind_t          kind;
    logic [RPM_W-1:0]   mx;
    logic [RPM_W-1:0]   meas;
    logic [PULSE_W-1:0] pulse;
  } q_item_t;

  typedef struct packed {
    logic    push;
    q_item_t item;
  } q_push_t;

  typedef struct packed {
    logic    avail;
    q_item_t item;
  } q_head_t;

endpackage

`default_nettype wire

// File: rtl/core/fpse_div.sv
// ----------------------------------------------------------------------------
// fpse_div
// Restoring divider, one quotient bit per cycle, shared by both envelope
// divisions.
// ----------------------------------------------------------------------------
`default_nettype none

module fpse_div (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  input  wire logic [fpse_pkg::SCALED_W-1:0] dividend,
  input  wire logic [fpse_pkg::SCALED_W-1:0] divisor,
  output logic                              done,
  output logic [fpse_pkg::SCALED_W-1:0]     quotient
);
  import fpse_pkg::*;

  logic                 busy;
  logic [DIV_CNT_W-1:0] cnt;
  logic [SCALED_W:0]    rem;
  logic [SCALED_W-1:0]  quo;
  logic [SCALED_W-1:0]  dvs;
  logic [SCALED_W:0]    shifted;
  logic [SCALED_W:0]    trial;

  assign shifted  = {rem[SCALED_W-1:0], quo[SCALED_W-1]};
  assign trial    = shifted - {1'b0, dvs};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= DIV_CNT_W'(SCALED_W);
        rem  <= '0;
        quo  <= dividend;
        dvs  <= divisor;
      end else if (busy) begin
        if (!trial[SCALED_W]) begin
          rem <= trial;
          quo <= {quo[SCALED_W-2:0], 1'b1};
        end else begin
          rem <= shifted;
          quo <= {quo[SCALED_W-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == DIV_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/fpse_queue.sv
// ----------------------------------------------------------------------------
// fpse_queue
// Short FIFO between the command front end and the execution back end.
// ----------------------------------------------------------------------------
`default_nettype none

module fpse_queue (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire fpse_pkg::q_push_t wr,
  output logic                   full,
  input  wire logic              pop,
  output fpse_pkg::q_head_t      head
);
  import fpse_pkg::*;

  q_item_t             slots [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr;
  logic [QUEUE_AW-1:0] rd_ptr;
  logic [QUEUE_CW-1:0] count;
  logic                do_push;
  logic                do_pop;

  assign full       = (count == QUEUE_CW'(QUEUE_DEPTH));
  assign head.avail = (count != '0);
  assign head.item  = slots[rd_ptr];
  assign do_push    = wr.push && !full;
  assign do_pop     = pop && head.avail;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= wr.item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/fpse_front.sv
// ----------------------------------------------------------------------------
// fpse_front
// Command front end: accepts words, validates arguments and classifies each
// command for the back end. Tracks the calibrated ceiling rpm.
// ----------------------------------------------------------------------------
`default_nettype none

module fpse_front (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cmd_valid,
  output logic                     cmd_ready,
  input  wire fpse_pkg::cmd_word_t cmd,
  input  wire logic                q_full,
  output fpse_pkg::q_push_t        wr
);
  import fpse_pkg::*;

  logic [RPM_W-1:0]   ceiling;
  logic [31:0]        raw;
  logic [31:0]        mx_sel;
  logic               env_ok;
  logic [PULSE_W-1:0] pulse_clamped;
  cmd_kind_t          kind;

  assign raw       = cmd.value;
  assign cmd_ready = !q_full;

  always_comb begin
    if (cmd.op == OP_CALIBRATE) begin
      mx_sel = raw;
    end else if (ceiling != '0) begin
      mx_sel = 32'(ceiling);
    end else if (cmd.value > 32'sd100) begin
      mx_sel = raw;
    end else begin
      mx_sel = 32'(MIN_RPM);
    end
    env_ok = (mx_sel >= 32'(MIN_RPM)) && (mx_sel <= 32'(RPM_LIMIT)) &&
             (raw >= 32'd1) && (raw <= mx_sel);
  end

  always_comb begin
    if (cmd.value < 32'(PULSE_MIN)) begin
      pulse_clamped = PULSE_W'(PULSE_MIN);
    end else if (cmd.value > 32'(PULSE_MAX)) begin
      pulse_clamped = PULSE_W'(PULSE_MAX);
    end else begin
      pulse_clamped = cmd.value[PULSE_W-1:0];
    end
  end

  always_comb begin
    unique case (cmd.op)
      OP_ENABLE:    kind = CMD_ENABLE;
      OP_DISABLE:   kind = CMD_DISABLE;
      OP_CALIBRATE: kind = env_ok ? CMD_ENVELOPE : CMD_INVALID;
      OP_RPM:       kind = env_ok ? CMD_ENVELOPE : CMD_INVALID;
      OP_RUN:       kind = (ceiling != '0) ? CMD_RUN : CMD_REFUSED;
      OP_PULSE:     kind = CMD_PULSE;
      default:      kind = CMD_INVALID;
    endcase
  end

  assign wr.push       = cmd_valid && cmd_ready;
  assign wr.item.kind  = kind;
  assign wr.item.mx    = mx_sel[RPM_W-1:0];
  assign wr.item.meas  = raw[RPM_W-1:0];
  assign wr.item.pulse = pulse_clamped;

  always_ff @(posedge clk) begin
    if (rst) begin
      ceiling <= '0;
    end else if (wr.push && kind == CMD_ENVELOPE) begin
      ceiling <= mx_sel[RPM_W-1:0];
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/fpse_back.sv
// ----------------------------------------------------------------------------
// fpse_back
// Execution back end: applies commands to the envelope state, runs the two
// envelope divisions and holds the result register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "fan_pulse_safety_envelope_macros.svh"

module fpse_back (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire fpse_pkg::q_head_t head,
  output logic                   pop,
  output logic                   rsp_valid,
  input  wire logic              rsp_ready,
  output fpse_pkg::rsp_word_t    rsp
);
  import fpse_pkg::*;

  back_state_t state;
  back_state_t state_next;

  logic                  cal;
  logic                  en;
  logic [SCALED_W-1:0]   slope;
  logic [DUTY_W-1:0]     safe_duty;
  logic [HZ_W-1:0]       hz;
  logic [DUTY_W-1:0]     ampc;
  logic [PULSE_W-1:0]    pulse;
  logic [DUTY_W-1:0]     amp;
  logic [COUNT_BITS-1:0] run_cnt;

  logic                  cal_next;
  logic                  en_next;
  logic [SCALED_W-1:0]   slope_next;
  logic [DUTY_W-1:0]     safe_duty_next;
  logic [HZ_W-1:0]       hz_next;
  logic [DUTY_W-1:0]     ampc_next;
  logic [PULSE_W-1:0]    pulse_next;
  logic [DUTY_W-1:0]     amp_next;
  logic [COUNT_BITS-1:0] run_cnt_next;
  status_t               status_next;
  logic                  rsp_load;

  logic [RPM_W-1:0]      mx_r;
  logic [SCALED_W-1:0]   meas_r;
  logic [SCALED_W-1:0]   scaled;
  logic [SCALED_W-1:0]   s_tmp;
  logic [SCALED_W-1:0]   fl_tmp;

  logic                  rsp_free;
  logic                  div_start;
  logic [SCALED_W-1:0]   div_divisor;
  logic                  div_done;
  logic [SCALED_W-1:0]   div_quo;

  logic [HZ_PROD_W-1:0]  hz_prod;
  logic [HZ_W-1:0]       hz_quo;
  logic [HZ_W-1:0]       hz_calc;
  logic [DUTY_W-1:0]     fl_clamped;
  logic [DUTY_W-1:0]     fl_margin;
  logic [DUTY_W-1:0]     safe_calc;
  logic [DUTY_W-1:0]     ampc_calc;

  assign rsp_free    = !rsp_valid || rsp_ready;
  assign div_start   = (state == BK_SLOPE_GO) || (state == BK_FLOOR_GO);
  assign div_divisor = (state == BK_SLOPE_GO) ? meas_r : s_tmp;

  fpse_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (scaled),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quo)
  );

  assign hz_prod = HZ_PROD_W'(mx_r) * HZ_PROD_W'(HZ_MUL);
  assign hz_quo  = HZ_W'(hz_prod >> HZ_SHIFT);
  assign hz_calc = (hz_quo == '0) ? HZ_W'(1) : hz_quo;

  always_comb begin
    if (fl_tmp < SCALED_W'(DUTY_MIN)) begin
      fl_clamped = DUTY_W'(DUTY_MIN);
    end else if (fl_tmp > SCALED_W'(DUTY_MAX)) begin
      fl_clamped = DUTY_W'(DUTY_MAX);
    end else begin
      fl_clamped = fl_tmp[DUTY_W-1:0];
    end
    fl_margin = fl_clamped + DUTY_W'(STALL_MARGIN);
    safe_calc = (fl_margin > DUTY_W'(DUTY_MAX)) ? DUTY_W'(DUTY_MAX) : fl_margin;
    ampc_calc = (safe_calc == DUTY_W'(DUTY_MAX)) ? DUTY_W'(1)
                                                  : DUTY_W'(DUTY_MAX) - safe_calc;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE: begin
        if (head.avail && rsp_free && head.item.kind == CMD_ENVELOPE) begin
          state_next = BK_SLOPE_GO;
        end
      end
      BK_SLOPE_GO: begin
        state_next = BK_SLOPE_WAIT;
      end
      BK_SLOPE_WAIT: begin
        if (div_done) begin
          state_next = BK_FLOOR_GO;
        end
      end
      BK_FLOOR_GO: begin
        state_next = BK_FLOOR_WAIT;
      end
      BK_FLOOR_WAIT: begin
        if (div_done) begin
          state_next = BK_EMIT;
        end
      end
      BK_EMIT: begin
        if (rsp_free) begin
          state_next = BK_IDLE;
        end
      end
      default: begin
        state_next = BK_IDLE;
      end
    endcase
  end

  always_comb begin
    pop            = (state == BK_IDLE) && head.avail && rsp_free;
    rsp_load       = 1'b0;
    status_next    = ST_OK;
    cal_next       = cal;
    en_next        = en;
    slope_next     = slope;
    safe_duty_next = safe_duty;
    hz_next        = hz;
    ampc_next      = ampc;
    pulse_next     = pulse;
    amp_next       = amp;
    run_cnt_next   = run_cnt;
    if (pop) begin
      rsp_load = (head.item.kind != CMD_ENVELOPE);
      unique case (head.item.kind)
        CMD_ENABLE:   en_next = 1'b1;
        CMD_DISABLE:  en_next = 1'b0;
        CMD_ENVELOPE: en_next = en;
        CMD_RUN: begin
          if (pulse > PULSE_W'(hz)) begin
            pulse_next = PULSE_W'(hz);
          end
          if (amp > ampc) begin
            amp_next = ampc;
          end
          run_cnt_next = run_cnt + 1'b1;
        end
        CMD_REFUSED:  status_next = ST_REFUSED;
        CMD_PULSE:    pulse_next = head.item.pulse;
        CMD_INVALID:  status_next = ST_INVALID;
        default:      status_next = ST_INVALID;
      endcase
    end else if (state == BK_EMIT && rsp_free) begin
      rsp_load       = 1'b1;
      cal_next       = 1'b1;
      slope_next     = s_tmp;
      safe_duty_next = safe_calc;
      hz_next        = hz_calc;
      ampc_next      = ampc_calc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_IDLE;
      rsp_valid <= 1'b0;
      cal       <= 1'b0;
      en        <= 1'b0;
      slope     <= '0;
      safe_duty <= '0;
      hz        <= '0;
      ampc      <= '0;
      pulse     <= PULSE_W'(PULSE_RESET);
      amp       <= DUTY_W'(AMP_RESET);
      run_cnt   <= '0;
    end else begin
      state     <= state_next;
      cal       <= cal_next;
      en        <= en_next;
      slope     <= slope_next;
      safe_duty <= safe_duty_next;
      hz        <= hz_next;
      ampc      <= ampc_next;
      pulse     <= pulse_next;
      amp       <= amp_next;
      run_cnt   <= run_cnt_next;
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && head.item.kind == CMD_ENVELOPE) begin
      mx_r   <= head.item.mx;
      meas_r <= SCALED_W'(head.item.meas);
      scaled <= SCALED_W'(head.item.mx) * SCALED_W'(100);
    end
    if (state == BK_SLOPE_WAIT && div_done) begin
      s_tmp <= div_quo;
    end
    if (state == BK_FLOOR_WAIT && div_done) begin
      fl_tmp <= div_quo;
    end
    if (rsp_load) begin
      rsp.status            <= status_next;
      rsp.calibrated        <= cal_next;
      rsp.enabled           <= en_next;
      rsp.pulse_rate_hz     <= 11'(pulse_next);
      rsp.amplitude_level   <= 7'(amp_next);
      rsp.min_duty_level    <= 7'(safe_duty_next);
      rsp.pulse_ceiling_hz  <= 8'(hz_next);
      rsp.amplitude_ceiling <= 7'(ampc_next);
      rsp.rpm_slope         <= 22'(slope_next);
      rsp.run_total         <= 32'(run_cnt_next);
    end
  end

  `FPSE_ASSERT_IMP(a_div_done_in_wait, clk, rst, div_done, (state == BK_SLOPE_WAIT) || (state == BK_FLOOR_WAIT))
  `FPSE_ASSERT_IMP(a_cal_slope_floor, clk, rst, cal, slope >= SCALED_W'(100))
  `FPSE_ASSERT_IMP(a_cal_duty_range, clk, rst, cal, (safe_duty >= DUTY_W'(DUTY_MIN)) && (safe_duty <= DUTY_W'(DUTY_MAX)) && (ampc != '0))
  `FPSE_ASSERT_NXT(a_emit_commits, clk, rst, (state == BK_EMIT) && rsp_free, rsp_valid && cal && (state == BK_IDLE))

endmodule

`default_nettype wire

// File: rtl/core/fan_pulse_safety_envelope.sv
// ----------------------------------------------------------------------------
// fan_pulse_safety_envelope
// Command interpreter and safety envelope for a fan pulse program.
//
//   channel  dir  handshake              payload
//   cmd      in   cmd_valid / cmd_ready  cmd_word_t  (op, value)
//   rsp      out  rsp_valid / rsp_ready  rsp_word_t  (status .. run_total)
//
// Enable, disable, run, pulse and rejected commands are applied in the back
// end as they are popped; an accepted calibrate or rpm command waits on the
// one serial divider, used for the slope and then the floor duty. A 2-word
// queue sits between the front end and the back end, so commands are taken
// while the back end works or the result waits. Reset is synchronous on rst;
// no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module fan_pulse_safety_envelope (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cmd_valid,
  output logic                     cmd_ready,
  input  wire fpse_pkg::cmd_word_t cmd,
  output logic                     rsp_valid,
  input  wire logic                rsp_ready,
  output fpse_pkg::rsp_word_t      rsp
);
  import fpse_pkg::*;

  q_push_t q_wr;
  q_head_t q_head;
  logic    q_full;
  logic    q_pop;

  fpse_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .q_full    (q_full),
    .wr        (q_wr)
  );

  fpse_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .wr   (q_wr),
    .full (q_full),
    .pop  (q_pop),
    .head (q_head)
  );

  fpse_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (q_head),
    .pop       (q_pop),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

endmodule

`default_nettype wire

// File: test/tb_fan_pulse_safety_envelope.sv
// ----------------------------------------------------------------------------
// tb_fan_pulse_safety_envelope
// Self-checking bench for the fan pulse safety envelope. Commands go in over
// the cmd channel. A behavioral model of the envelope logic predicts one
// response word per command. Each response is compared with the oldest
// prediction, field by field. A directed pass covers the field extremes,
// every command, argument rejection and run refusal before calibration.
// Random traffic then runs mostly valid calibrate/rpm/run/pulse sequences
// with some noise, in four phases of sender and receiver idling.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_fan_pulse_safety_envelope;
  timeunit 1ns;
  timeprecision 1ps;

  import fpse_pkg::*;

  localparam logic [2:0] OP_RESERVED_LO = 3'd6;
  localparam logic [2:0] OP_RESERVED_HI = 3'd7;
  localparam int         MAX_REPORTS    = 10;

  logic      clk;
  logic      rst = 1'b1;
  logic      cmd_valid = 1'b0;
  logic      cmd_ready;
  cmd_word_t cmd = '0;
  logic      rsp_valid;
  logic      rsp_ready = 1'b0;
  rsp_word_t rsp;

  fan_pulse_safety_envelope u_dut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  // envelope state as the block should hold it
  logic                  is_calibrated = 1'b0;
  logic                  is_enabled    = 1'b0;
  logic [31:0]           max_rpm       = '0;
  logic [31:0]           slope_rpm     = '0;
  logic [31:0]           floor_duty    = '0;
  logic [31:0]           hz_cap        = '0;
  logic [31:0]           amp_cap       = '0;
  logic [31:0]           pulse_rate    = PULSE_RESET;
  logic [31:0]           amp_pct       = AMP_RESET;
  logic [COUNT_BITS-1:0] run_count     = '0;

  rsp_word_t pending_responses[$];
  int        mismatch_count = 0;
  int        send_idle_pct  = 0;
  int        stall_pct      = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("fan_pulse_safety_envelope verification failed");
    $finish;
  end

  function automatic status_t fit_envelope(logic [31:0] mx, logic [31:0] meas);
    logic [63:0] scaled;
    logic [63:0] s;
    logic [63:0] fl;
    logic [31:0] safe;
    if (mx < MIN_RPM || mx > RPM_LIMIT || meas < 1 || meas > mx) begin
      return ST_INVALID;
    end
    scaled = mx * 64'd100;
    s = scaled / meas;
    if (s < 1) s = 1;
    fl = scaled / s;
    if (fl < DUTY_MIN) fl = DUTY_MIN;
    if (fl > DUTY_MAX) fl = DUTY_MAX;
    safe = fl[31:0] + STALL_MARGIN;
    if (safe > DUTY_MAX) safe = DUTY_MAX;
    if (safe < DUTY_MIN) safe = DUTY_MIN;
    slope_rpm     = s[31:0];
    floor_duty    = safe;
    max_rpm       = mx;
    hz_cap        = mx / 60 / 3;
    if (hz_cap < 1) hz_cap = 1;
    amp_cap       = DUTY_MAX - safe;
    if (amp_cap < 1) amp_cap = 1;
    is_calibrated = 1'b1;
    return ST_OK;
  endfunction

  function automatic rsp_word_t envelope_response(cmd_word_t w);
    rsp_word_t   r;
    status_t     st;
    logic [31:0] mx;
    st = ST_OK;
    case (w.op)
      OP_ENABLE:    is_enabled = 1'b1;
      OP_DISABLE:   is_enabled = 1'b0;
      OP_CALIBRATE: st = fit_envelope(w.value, w.value);
      OP_RPM: begin
        if (max_rpm != 0) mx = max_rpm;
        else if (w.value > MIN_RPM) mx = w.value;
        else mx = MIN_RPM;
        st = fit_envelope(mx, w.value);
      end
      OP_RUN: begin
        if (!is_calibrated) begin
          st = ST_REFUSED;
        end else begin
          if (pulse_rate > hz_cap) pulse_rate = hz_cap;
          if (amp_pct > amp_cap) amp_pct = amp_cap;
          run_count = run_count + 1'b1;
        end
      end
      OP_PULSE: begin
        if (w.value < PULSE_MIN) pulse_rate = PULSE_MIN;
        else if (w.value > PULSE_MAX) pulse_rate = PULSE_MAX;
        else pulse_rate = w.value;
      end
      default: st = ST_INVALID;
    endcase
    r.status            = st;
    r.calibrated        = is_calibrated;
    r.enabled           = is_enabled;
    r.pulse_rate_hz     = pulse_rate[10:0];
    r.amplitude_level   = amp_pct[6:0];
    r.min_duty_level    = floor_duty[6:0];
    r.pulse_ceiling_hz  = hz_cap[7:0];
    r.amplitude_ceiling = amp_cap[6:0];
    r.rpm_slope         = slope_rpm[21:0];
    r.run_total         = run_count[31:0];
    return r;
  endfunction

  task automatic note_mismatch(string what, logic [63:0] want, logic [63:0] got);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) begin
      $display("mismatch %s: expected %0d, got %0d", what, want, got);
    end
  endtask

  task automatic check_response(rsp_word_t got);
    rsp_word_t want;
    if (pending_responses.size() == 0) begin
      note_mismatch("unexpected word, run_total", 0, got.run_total);
      return;
    end
    want = pending_responses.pop_front();
    if (got.status !== want.status)
      note_mismatch("status", want.status, got.status);
    if (got.calibrated !== want.calibrated)
      note_mismatch("calibrated", want.calibrated, got.calibrated);
    if (got.enabled !== want.enabled)
      note_mismatch("enabled", want.enabled, got.enabled);
    if (got.pulse_rate_hz !== want.pulse_rate_hz)
      note_mismatch("pulse_rate_hz", want.pulse_rate_hz, got.pulse_rate_hz);
    if (got.amplitude_level !== want.amplitude_level)
      note_mismatch("amplitude_level", want.amplitude_level, got.amplitude_level);
    if (got.min_duty_level !== want.min_duty_level)
      note_mismatch("min_duty_level", want.min_duty_level, got.min_duty_level);
    if (got.pulse_ceiling_hz !== want.pulse_ceiling_hz)
      note_mismatch("pulse_ceiling_hz", want.pulse_ceiling_hz, got.pulse_ceiling_hz);
    if (got.amplitude_ceiling !== want.amplitude_ceiling)
      note_mismatch("amplitude_ceiling", want.amplitude_ceiling, got.amplitude_ceiling);
    if (got.rpm_slope !== want.rpm_slope)
      note_mismatch("rpm_slope", want.rpm_slope, got.rpm_slope);
    if (got.run_total !== want.run_total)
      note_mismatch("run_total", want.run_total, got.run_total);
  endtask

  // stall the response side and check every word taken
  always @(posedge clk) begin
    rsp_ready <= ($urandom_range(99) >= stall_pct);
    if (!rst && rsp_valid && rsp_ready) check_response(rsp);
  end

  task automatic send_command(logic [2:0] op, logic signed [31:0] value);
    cmd_word_t w;
    w.op    = op;
    w.value = value;
    while ($urandom_range(99) < send_idle_pct) begin
      cmd_valid <= 1'b0;
      @(posedge clk);
    end
    cmd_valid <= 1'b1;
    cmd       <= w;
    @(posedge clk);
    while (!cmd_ready) @(posedge clk);
    pending_responses.push_back(envelope_response(w));
  endtask

  task automatic test_directed_commands();
    send_idle_pct = 0;
    stall_pct     = 0;
    send_command(OP_RUN, 0);
    send_command(OP_RESERVED_LO, 32'h7FFF_FFFF);
    send_command(OP_RESERVED_HI, 32'h8000_0000);
    send_command(OP_ENABLE, 0);
    send_command(OP_DISABLE, -1);
    send_command(OP_ENABLE, 0);
    send_command(OP_PULSE, 32'sh8000_0000);
    send_command(OP_PULSE, 32'sh7FFF_FFFF);
    send_command(OP_PULSE, PULSE_MIN - 1);
    send_command(OP_PULSE, PULSE_MAX + 1);
    // rpm before any calibration derives the ceiling from the argument, floored at MIN_RPM
    send_command(OP_RPM, 0);
    send_command(OP_RPM, -5);
    send_command(OP_RPM, 50);
    send_command(OP_RUN, 0);
    send_command(OP_CALIBRATE, MIN_RPM - 1);
    send_command(OP_CALIBRATE, RPM_LIMIT + 1);
    send_command(OP_CALIBRATE, -1);
    send_command(OP_CALIBRATE, MIN_RPM);
    send_command(OP_CALIBRATE, RPM_LIMIT);
    send_command(OP_RPM, RPM_LIMIT);
    send_command(OP_RPM, 1);
    send_command(OP_RPM, RPM_LIMIT + 1);
    send_command(OP_RUN, 0);
    send_command(OP_PULSE, PULSE_MAX);
    send_command(OP_RUN, 0);
  endtask

  task automatic test_random_traffic(int count, int idle_pct, int stall);
    int                 pick;
    logic [2:0]         op;
    logic signed [31:0] value;
    send_idle_pct = idle_pct;
    stall_pct     = stall;
    repeat (count) begin
      pick  = $urandom_range(99);
      value = $urandom;
      if (pick < 12) begin
        op = OP_CALIBRATE;
        if ($urandom_range(3) == 0) value = $urandom_range(MIN_RPM, 600);
        else value = $urandom_range(MIN_RPM, RPM_LIMIT);
      end else if (pick < 32) begin
        op = OP_RPM;
        if (max_rpm == 0) value = $urandom_range(1, MIN_RPM);
        else if ($urandom_range(3) == 0) value = $urandom_range(1, 20);
        else value = $urandom_range(1, max_rpm);
      end else if (pick < 55) begin
        op = OP_RUN;
      end else if (pick < 70) begin
        op = OP_PULSE;
        case ($urandom_range(3))
          0: value = -$signed(32'($urandom_range(1, 100)));
          1: value = $urandom;
          default: value = $urandom_range(0, PULSE_MAX + 200);
        endcase
      end else if (pick < 80) begin
        op = ($urandom_range(1) == 0) ? OP_ENABLE : OP_DISABLE;
      end else begin
        // noise: any op, any argument
        op = 3'($urandom_range(7));
        if ($urandom_range(3) == 0) value = $urandom_range(0, RPM_LIMIT + 100);
      end
      send_command(op, value);
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_directed_commands();
    test_random_traffic(256, 0, 0);
    test_random_traffic(256, 47, 0);
    test_random_traffic(256, 0, 47);
    test_random_traffic(256, 33, 33);
    cmd_valid <= 1'b0;
    while (pending_responses.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("fan_pulse_safety_envelope verification clean");
    end else begin
      $display("fan_pulse_safety_envelope verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: fan_pulse_safety_envelope.f
+incdir+rtl/core
rtl/core/fpse_pkg.sv
rtl/core/fpse_div.sv
rtl/core/fpse_queue.sv
rtl/core/fpse_front.sv
rtl/core/fpse_back.sv
rtl/core/fan_pulse_safety_envelope.sv
test/tb_fan_pulse_safety_envelope.sv
